@@ hdl/hmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_pkg
// shared types and constants for the histogram median filter
// ----------------------------------------------------------------------------
package hmf_pkg;

   localparam int GREY_LEVELS = 256;
   localparam int GREY_W      = 8;
   localparam int SCAN_W      = 9;
   localparam int CUM_W       = 17;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
   localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_FILL  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

@@ hdl/hmf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_ram
// simple dual-port ram, one write port, one registered read port (read-first)
// ----------------------------------------------------------------------------
module hmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/histogram_median_filter_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_median_filter_2d
// raster-order 2-d median filter: line store ram plus 256-bin histogram ram
// ----------------------------------------------------------------------------
// border beat: accepted, no result
// interior beat: the result beat follows one line store read per window pixel and
//   one histogram read per grey level
// one beat in flight; the next beat can be accepted the cycle after the result beat is taken
// reset: synchronous; then a histogram clearing pass over all 256 bins, req_stall high
module histogram_median_filter_2d #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_WINDOW = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_median,
   output logic [10:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic        rsp_last_of_frame,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int NW    = $clog2(MAX_WINDOW + 1);
   localparam int SW    = $clog2(MAX_WINDOW);
   localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int WLIM  = (MAX_WINDOW - 1) | 1;
   localparam int WSW   = $clog2(WLIM * WLIM + 1);

   hmf_pkg::state_type state_ff, state_in;

   logic [11:0] cfg_w_ff;
   logic [12:0] cfg_h_ff;
   logic [3:0]  cfg_m_ff;
   logic [3:0]  cfg_n_ff;

   logic [CW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [NW-1:0] m_eff;
   logic [NW-1:0] n_eff;
   logic [WSW-1:0] wsize;
   logic [3:0] m_odd;
   logic [3:0] n_odd;

   logic [CW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic [CW-1:0] x;
   logic [YW-1:0] y;
   logic [SW-1:0] sy;
   logic [SW-1:0] sy_next;
   logic          produce;
   logic          accept;

   logic [CW-1:0] fc_ff, fc_in;
   logic [CW-1:0] c0_ff, c0_in;
   logic [CW-1:0] xe_ff, xe_in;
   logic [SW-1:0] frs_ff, frs_in;
   logic [NW-1:0] frc_ff, frc_in;

   logic          v1_ff, v1_in;
   logic          v2_ff, v2_in;
   logic [7:0]    bin2_ff, bin2_in;
   logic          wr_en_ff, wr_en_in;
   logic [7:0]    wr_bin_ff, wr_bin_in;
   logic [7:0]    wr_val_ff, wr_val_in;
   logic [7:0]    cur_count;

   logic [hmf_pkg::SCAN_W-1:0] sc_ff, sc_in;
   logic                       sv_ff, sv_in;
   logic [7:0]                 sb_ff, sb_in;
   logic [hmf_pkg::CUM_W-1:0]  cum_ff, cum_in;
   logic                       found_ff, found_in;

   logic [7:0]  med_ff, med_in;
   logic [10:0] ocol_ff, ocol_in;
   logic [11:0] orow_ff, orow_in;
   logic        olast_ff, olast_in;

   logic          ls_we;
   logic [AW-1:0] ls_waddr;
   logic          ls_re;
   logic [AW-1:0] ls_raddr;
   logic [7:0]    ls_rdata;

   logic          hist_we;
   logic [7:0]    hist_waddr;
   logic [7:0]    hist_wdata;
   logic          hist_re;
   logic [7:0]    hist_raddr;
   logic [7:0]    hist_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= 12'd640;
         cfg_h_ff <= 13'd480;
         cfg_m_ff <= 4'd3;
         cfg_n_ff <= 4'd3;
      end else if (csr_we) begin
         case (csr_index)
            hmf_pkg::REG_IMAGE_WIDTH:   cfg_w_ff <= csr_wdata[11:0];
            hmf_pkg::REG_IMAGE_HEIGHT:  cfg_h_ff <= csr_wdata;
            hmf_pkg::REG_WINDOW_WIDTH:  cfg_m_ff <= csr_wdata[3:0];
            hmf_pkg::REG_WINDOW_HEIGHT: cfg_n_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   always_comb begin
      if (cfg_w_ff == 12'd0) begin
         w_eff = CW'(1);
      end else if (32'(cfg_w_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg_w_ff);
      end
      if (cfg_h_ff == 13'd0) begin
         h_eff = YW'(1);
      end else if (32'(cfg_h_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(cfg_h_ff);
      end
      m_odd = cfg_m_ff | 4'd1;
      n_odd = cfg_n_ff | 4'd1;
      m_eff = (32'(m_odd) > 32'(WLIM)) ? NW'(WLIM) : NW'(m_odd);
      n_eff = (32'(n_odd) > 32'(WLIM)) ? NW'(WLIM) : NW'(n_odd);
      wsize = WSW'(32'(m_eff) * 32'(n_eff));
   end

   assign accept = req_valid && !req_stall;

   // position of the incoming pixel
   always_comb begin
      x  = col_ff;
      y  = row_ff;
      sy = slot_ff;
      if (32'(col_ff) >= 32'(w_eff)) begin
         x  = '0;
         y  = row_ff + YW'(1);
         sy = (32'(slot_ff) == MAX_WINDOW - 1) ? '0 : slot_ff + SW'(1);
      end
      if (32'(y) >= 32'(h_eff)) begin
         y  = '0;
         sy = '0;
      end
      produce = (32'(x) + 1 >= 32'(m_eff)) && (32'(y) + 1 >= 32'(n_eff));
      sy_next = (32'(sy) == MAX_WINDOW - 1) ? '0 : sy + SW'(1);
   end

   assign ls_we    = accept;
   assign ls_waddr = AW'(32'(sy) * MAX_WIDTH + 32'(x));
   assign ls_re    = (state_ff == hmf_pkg::ST_FILL);
   assign ls_raddr = AW'(32'(frs_ff) * MAX_WIDTH + 32'(fc_ff));

   hmf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ls_we),
      .waddr (ls_waddr),
      .wdata (req_pixel),
      .re    (ls_re),
      .raddr (ls_raddr),
      .rdata (ls_rdata)
   );

   // histogram port muxing
   always_comb begin
      cur_count = (wr_en_ff && wr_bin_ff == bin2_ff) ? wr_val_ff : hist_rdata;
      hist_re    = 1'b0;
      hist_raddr = ls_rdata;
      hist_we    = 1'b0;
      hist_waddr = bin2_ff;
      hist_wdata = cur_count + 8'd1;
      case (state_ff)
         hmf_pkg::ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = sc_ff[7:0];
            hist_wdata = '0;
         end
         hmf_pkg::ST_SCAN: begin
            hist_re    = (32'(sc_ff) < hmf_pkg::GREY_LEVELS);
            hist_raddr = sc_ff[7:0];
            hist_we    = hist_re;
            hist_waddr = sc_ff[7:0];
            hist_wdata = '0;
         end
         default: begin
            hist_re = v1_ff;
            hist_we = v2_ff;
         end
      endcase
   end

   hmf_ram #(
      .WIDTH (hmf_pkg::GREY_W),
      .DEPTH (hmf_pkg::GREY_LEVELS)
   ) u_histogram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (hist_re),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   // control
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      slot_in   = slot_ff;
      fc_in     = fc_ff;
      c0_in     = c0_ff;
      xe_in     = xe_ff;
      frs_in    = frs_ff;
      frc_in    = frc_ff;
      v1_in     = (state_ff == hmf_pkg::ST_FILL);
      v2_in     = v1_ff;
      bin2_in   = ls_rdata;
      wr_en_in  = v2_ff;
      wr_bin_in = bin2_ff;
      wr_val_in = cur_count + 8'd1;
      sc_in     = sc_ff;
      sv_in     = 1'b0;
      sb_in     = sc_ff[7:0];
      cum_in    = cum_ff;
      found_in  = found_ff;
      med_in    = med_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      olast_in  = olast_ff;
      case (state_ff)
         hmf_pkg::ST_CLEAR: begin
            sc_in = sc_ff + hmf_pkg::SCAN_W'(1);
            if (32'(sc_ff) == hmf_pkg::GREY_LEVELS - 1) begin
               state_in = hmf_pkg::ST_IDLE;
            end
         end
         hmf_pkg::ST_IDLE: begin
            if (accept) begin
               col_in  = x + CW'(1);
               row_in  = y;
               slot_in = sy;
               if (32'(col_in) >= 32'(w_eff)) begin
                  col_in  = '0;
                  row_in  = y + YW'(1);
                  slot_in = sy_next;
                  if (32'(row_in) >= 32'(h_eff)) begin
                     row_in  = '0;
                     slot_in = '0;
                  end
               end
               ocol_in  = 11'(32'(x) - 32'(m_eff) / 2);
               orow_in  = 12'(32'(y) - 32'(n_eff) / 2);
               olast_in = (32'(x) == 32'(w_eff) - 1) && (32'(y) == 32'(h_eff) - 1);
               c0_in    = CW'(32'(x) + 1 - 32'(m_eff));
               fc_in    = CW'(32'(x) + 1 - 32'(m_eff));
               xe_in    = x;
               frc_in   = n_eff - NW'(1);
               if (32'(sy) >= 32'(n_eff) - 1) begin
                  frs_in = SW'(32'(sy) - (32'(n_eff) - 1));
               end else begin
                  frs_in = SW'(32'(sy) + MAX_WINDOW - (32'(n_eff) - 1));
               end
               if (produce) begin
                  state_in = hmf_pkg::ST_FILL;
               end
            end
         end
         hmf_pkg::ST_FILL: begin
            if (fc_ff == xe_ff) begin
               fc_in  = c0_ff;
               frs_in = (32'(frs_ff) == MAX_WINDOW - 1) ? '0 : frs_ff + SW'(1);
               frc_in = frc_ff - NW'(1);
               if (frc_ff == '0) begin
                  state_in = hmf_pkg::ST_DRAIN;
               end
            end else begin
               fc_in = fc_ff + CW'(1);
            end
         end
         hmf_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = hmf_pkg::ST_SCAN;
               sc_in    = '0;
               cum_in   = '0;
               found_in = 1'b0;
            end
         end
         hmf_pkg::ST_SCAN: begin
            if (32'(sc_ff) < hmf_pkg::GREY_LEVELS) begin
               sv_in = 1'b1;
               sc_in = sc_ff + hmf_pkg::SCAN_W'(1);
            end
            if (sv_ff) begin
               cum_in = cum_ff + hmf_pkg::CUM_W'(hist_rdata);
               if (!found_ff && (32'(cum_in) * 2 > 32'(wsize))) begin
                  found_in = 1'b1;
                  med_in   = sb_ff;
               end
               if (32'(sb_ff) == hmf_pkg::GREY_LEVELS - 1) begin
                  state_in = hmf_pkg::ST_OUT;
                  if (!found_in) begin
                     med_in = sb_ff;
                  end
               end
            end
         end
         hmf_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = hmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmf_pkg::ST_CLEAR;
         col_ff   <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         wr_en_ff <= 1'b0;
         sc_ff    <= '0;
         sv_ff    <= 1'b0;
         found_ff <= 1'b0;
         cum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         slot_ff  <= slot_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         wr_en_ff <= wr_en_in;
         sc_ff    <= sc_in;
         sv_ff    <= sv_in;
         found_ff <= found_in;
         cum_ff   <= cum_in;
      end
   end

   always_ff @(posedge clock) begin
      fc_ff     <= fc_in;
      c0_ff     <= c0_in;
      xe_ff     <= xe_in;
      frs_ff    <= frs_in;
      frc_ff    <= frc_in;
      bin2_ff   <= bin2_in;
      wr_bin_ff <= wr_bin_in;
      wr_val_ff <= wr_val_in;
      sb_ff     <= sb_in;
      med_ff    <= med_in;
      ocol_ff   <= ocol_in;
      orow_ff   <= orow_in;
      olast_ff  <= olast_in;
   end

   assign req_stall         = (state_ff != hmf_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == hmf_pkg::ST_OUT);
   assign rsp_median        = med_ff;
   assign rsp_column        = ocol_ff;
   assign rsp_row           = orow_ff;
   assign rsp_last_of_frame = olast_ff;

`ifndef SYNTHESIS
   a_scan_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hmf_pkg::ST_SCAN && hist_re) |-> (hist_we && hist_wdata == 8'd0))
      else $error("scan read without clearing the bin");

   a_scan_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hmf_pkg::ST_SCAN) |-> (!v1_ff && !v2_ff))
      else $error("histogram scan while increments are pending");

   a_line_addr: assert property (@(posedge clock) disable iff (reset)
      ls_re |-> (32'(ls_raddr) < DEPTH))
      else $error("line store read beyond depth");
`endif

endmodule
